FILE: sv/kve_pkg.sv
// Shared constants for the keyframe volume envelope: field widths, command,
// mode and source codes, register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kve_pkg;

   // fixed field widths
   localparam int FRAC_W     = 16;   // Q0.16 fraction
   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int SRC_W      = 2;
   localparam int EASE_W     = 18;   // width of 3.0 - 2t in Q.16
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_BIT = 2;   // registers sit on 4-byte strides

   localparam int EMPTY_VOLUME_RESET = 8192;   // 1.0 in Q3.13

   localparam logic [EASE_W-1:0] EASE_THREE = 18'h30000;   // 3.0 in Q.16

   // request kind (tuser)
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // segment interpolation modes (codes not listed interpolate linearly)
   localparam logic [MODE_W-1:0] MODE_HOLD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EASE = 2'd2;

   // result source codes
   localparam logic [SRC_W-1:0] SRC_DEFAULT = 2'd0;
   localparam logic [SRC_W-1:0] SRC_FIRST   = 2'd1;
   localparam logic [SRC_W-1:0] SRC_LAST    = 2'd2;
   localparam logic [SRC_W-1:0] SRC_SEGMENT = 2'd3;

   // register indexes
   localparam logic CSR_IDX_EMPTY_VOLUME   = 1'b0;
   localparam logic CSR_IDX_KEYFRAME_COUNT = 1'b1;

endpackage

`default_nettype wire

FILE: sv/keyframe_volume_envelope.sv
// Keyframe volume envelope top level: request/result streams, register port,
// keyframe RAM and the search/interpolate sequencer.
// Depends on kve_pkg, kve_ram, kve_frac_div, kve_mul.
//
// Usage:
//  - req_* carries requests. tuser = cmd: write stores {time, level, mode} at
//    slot and gives no result; evaluate returns one result on rsp_*.
//  - rsp_tdata = volume (Q3.13), rsp_tuser = source (default / clamped first /
//    clamped last / segment).
//  - csr_*: empty-table volume at 0x0, keyframe_count at 0x4; write only while idle.
//  - Sequence: a write is stored as it is taken. An evaluate of an empty table
//    goes straight to the finish state; a clamp reads the first and then the
//    last key; a segment runs a binary search on the single RAM read port,
//    reads its left and right keys, then runs the fraction unit and a blend.
//    Ease mode adds a square and a cube step on the shared multiplier.
//  - One request is worked at a time; req_tready is high only when idle.
//  - A finished result sits in the output register; the next request is taken
//    while it waits. A further result waits in the sequencer until taken.
//  - Reset clears control, sets the empty-table volume to 1.0 and count to 0.
//    The keyframe RAM is not cleared: entries must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_volume_envelope #(
   parameter int MAX_KEYFRAMES = 64,
   parameter int TIME_WIDTH    = 32,
   parameter int LEVEL_WIDTH   = 16
) (
   input  wire logic clock,
   input  wire logic reset,

   // requests
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata: tick_time, slot, level, mode (low bit up), zero padded to bytes
   input  wire logic [((TIME_WIDTH + kve_pkg::SLOT_W + LEVEL_WIDTH + kve_pkg::MODE_W)
                       + 7) / 8 * 8 - 1:0] req_tdata,
   input  wire logic req_tuser,   // cmd

   // results
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [(LEVEL_WIDTH + 7) / 8 * 8 - 1:0] rsp_tdata,   // volume
   output logic [kve_pkg::SRC_W-1:0]              rsp_tuser,   // source

   // register port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [kve_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [kve_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [kve_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   import kve_pkg::*;

   localparam int AW        = $clog2(MAX_KEYFRAMES);
   localparam int CNT_W     = $clog2(MAX_KEYFRAMES + 1);
   localparam int SEL_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SLOT_X_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int KEY_W     = TIME_WIDTH + LEVEL_WIDTH + MODE_W;
   localparam int MUL_A_W   = (LEVEL_WIDTH > EASE_W) ? LEVEL_WIDTH : EASE_W;
   localparam int PROD_W    = MUL_A_W + FRAC_W;
   localparam int RSP_DATA_W = (LEVEL_WIDTH + 7) / 8 * 8;
   localparam int SLOT_LSB  = TIME_WIDTH;
   localparam int LEVEL_LSB = SLOT_LSB + SLOT_W;
   localparam int MODE_LSB  = LEVEL_LSB + LEVEL_WIDTH;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_FIRST     = 12'b0000_0000_0010,
      ST_LAST      = 12'b0000_0000_0100,
      ST_SEARCH    = 12'b0000_0000_1000,
      ST_LEFT      = 12'b0000_0001_0000,
      ST_RIGHT     = 12'b0000_0010_0000,
      ST_DIVIDE    = 12'b0000_0100_0000,
      ST_EASE_SQ   = 12'b0000_1000_0000,
      ST_EASE_CUBE = 12'b0001_0000_0000,
      ST_BLEND     = 12'b0010_0000_0000,
      ST_APPLY     = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   // ---------------- request fields ----------------
   logic [TIME_WIDTH-1:0]  req_time;
   logic [SLOT_W-1:0]      req_slot;
   logic [LEVEL_WIDTH-1:0] req_level;
   logic [MODE_W-1:0]      req_mode;
   logic                   req_accept;

   assign req_time  = req_tdata[TIME_WIDTH-1:0];
   assign req_slot  = req_tdata[SLOT_LSB +: SLOT_W];
   assign req_level = req_tdata[LEVEL_LSB +: LEVEL_WIDTH];
   assign req_mode  = req_tdata[MODE_LSB +: MODE_W];

   // ---------------- registers ----------------
   state_type              state_ff, state_in;
   logic [TIME_WIDTH-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       lo_ff, lo_in;
   logic [CNT_W-1:0]       hi_ff, hi_in;
   logic [AW-1:0]          addr_ff;
   logic [LEVEL_WIDTH-1:0] level0_ff, level0_in;
   logic [TIME_WIDTH-1:0]  t1_ff, t1_in;
   logic [LEVEL_WIDTH-1:0] l1_ff, l1_in;
   logic [MODE_W-1:0]      m1_ff, m1_in;
   logic                   rising_ff, rising_in;
   logic [LEVEL_WIDTH-1:0] diff_ff, diff_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic [LEVEL_WIDTH-1:0] vol_ff, vol_in;
   logic [SRC_W-1:0]       src_ff, src_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0] rsp_volume_ff, rsp_volume_in;
   logic [SRC_W-1:0]       rsp_source_ff, rsp_source_in;
   logic [LEVEL_WIDTH-1:0] empty_volume_ff, empty_volume_in;
   logic [COUNT_W-1:0]     keyframe_count_ff, keyframe_count_in;

   // ---------------- keyframe RAM ----------------
   logic                   wr_en;
   logic [SLOT_X_W-1:0]    slot_x;
   logic [AW-1:0]          rd_addr;
   logic [KEY_W-1:0]       rd_word;
   logic [TIME_WIDTH-1:0]  rd_time;
   logic [LEVEL_WIDTH-1:0] rd_level;
   logic [MODE_W-1:0]      rd_mode;

   assign slot_x = SLOT_X_W'(req_slot);
   // slots beyond the table are dropped
   assign wr_en  = req_accept && (req_tuser == CMD_WRITE)
                   && (slot_x < SLOT_X_W'(MAX_KEYFRAMES));

   kve_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_KEYFRAMES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_x[AW-1:0]),
      .wr_data ({req_mode, req_level, req_time}),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_time  = rd_word[TIME_WIDTH-1:0];
   assign rd_level = rd_word[TIME_WIDTH +: LEVEL_WIDTH];
   assign rd_mode  = rd_word[TIME_WIDTH + LEVEL_WIDTH +: MODE_W];

   // ---------------- fraction unit ----------------
   logic                  div_start;
   logic                  div_done;
   logic [FRAC_W-1:0]     div_quotient;
   logic [TIME_WIDTH-1:0] div_num;
   logic [TIME_WIDTH-1:0] div_den;

   assign div_num = q_ff - t1_ff;
   assign div_den = rd_time - t1_ff;

   kve_frac_div #(
      .WIDTH (TIME_WIDTH)
   ) u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------- shared multiplier ----------------
   logic [MUL_A_W-1:0] mul_a;
   logic [FRAC_W-1:0]  mul_b;
   logic [PROD_W-1:0]  product;
   logic [FRAC_W-1:0]  prod_hi;
   logic [EASE_W-1:0]  ease_gap;

   kve_mul #(
      .A_WIDTH (MUL_A_W),
      .B_WIDTH (FRAC_W)
   ) u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   assign prod_hi  = product[FRAC_W +: FRAC_W];   // (x * y) >> 16, Q0.16
   assign ease_gap = EASE_THREE - EASE_W'({frac_ff, 1'b0});

   // ---------------- sequencer ----------------
   logic                   q_lt, q_eq;
   logic [SEL_W-1:0]       count_sel;
   logic [CNT_W-1:0]       n_sat;
   logic [CNT_W-1:0]       mid_c, lo_nx, hi_nx, mid_nx;
   logic [LEVEL_WIDTH-1:0] delta;
   logic                   rsp_load;

   // query against whatever entry the RAM returned this cycle
   assign q_lt = (q_ff < rd_time);
   assign q_eq = (q_ff == rd_time);

   assign count_sel = SEL_W'(keyframe_count_ff);
   assign n_sat     = (count_sel > SEL_W'(MAX_KEYFRAMES)) ? CNT_W'(MAX_KEYFRAMES)
                                                          : CNT_W'(count_sel);

   // one binary-search step per cycle; the next probe address is issued here
   assign mid_c  = CNT_W'(addr_ff);
   assign lo_nx  = q_lt ? lo_ff : (mid_c + 1'b1);
   assign hi_nx  = q_lt ? mid_c : hi_ff;
   assign mid_nx = lo_nx + ((hi_nx - lo_nx) >> 1);

   assign delta = product[FRAC_W +: LEVEL_WIDTH];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      q_in      = q_ff;
      n_in      = n_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      level0_in = level0_ff;
      t1_in     = t1_ff;
      l1_in     = l1_ff;
      m1_in     = m1_ff;
      rising_in = rising_ff;
      diff_in   = diff_ff;
      frac_in   = frac_ff;
      vol_in    = vol_ff;
      src_in    = src_ff;
      rd_addr   = '0;
      div_start = 1'b0;
      mul_a     = MUL_A_W'(diff_ff);
      mul_b     = frac_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // entry 0 is always being read while idle
            if (req_accept && (req_tuser == CMD_EVAL)) begin
               q_in = req_time;
               n_in = n_sat;
               if (n_sat == '0) begin
                  vol_in   = empty_volume_ff;
                  src_in   = SRC_DEFAULT;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            level0_in = rd_level;
            rd_addr   = AW'(n_ff - 1'b1);
            if (q_lt || q_eq) begin
               vol_in   = rd_level;
               src_in   = SRC_FIRST;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            rd_addr = AW'(n_ff >> 1);   // first probe of the search
            if (!q_lt) begin
               vol_in   = rd_level;
               src_in   = SRC_LAST;
               state_in = ST_FINISH;
            end else begin
               lo_in    = '0;
               hi_in    = n_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if (lo_nx < hi_nx) begin
               rd_addr = AW'(mid_nx);
            end else if ((lo_nx == '0) || (lo_nx >= n_ff)) begin
               // unsorted table fell off an end
               vol_in   = level0_ff;
               src_in   = SRC_FIRST;
               state_in = ST_FINISH;
            end else begin
               rd_addr  = AW'(lo_nx - 1'b1);
               state_in = ST_LEFT;
            end
         end
         ST_LEFT: begin
            t1_in    = rd_time;
            l1_in    = rd_level;
            m1_in    = rd_mode;
            rd_addr  = AW'(lo_ff);
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            rising_in = (rd_level >= l1_ff);
            diff_in   = (rd_level >= l1_ff) ? (rd_level - l1_ff) : (l1_ff - rd_level);
            // degenerate segment, query outside it, or hold mode: left value
            if ((rd_time <= t1_ff) || (q_ff < t1_ff) || !q_lt || (m1_ff == MODE_HOLD)) begin
               vol_in   = l1_ff;
               src_in   = SRC_SEGMENT;
               state_in = ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               frac_in  = div_quotient;
               state_in = (m1_ff == MODE_EASE) ? ST_EASE_SQ : ST_BLEND;
            end
         end
         ST_EASE_SQ: begin
            mul_a    = MUL_A_W'(frac_ff);
            mul_b    = frac_ff;
            state_in = ST_EASE_CUBE;
         end
         ST_EASE_CUBE: begin
            // t2 * (3 - 2t)
            mul_a    = MUL_A_W'(ease_gap);
            mul_b    = prod_hi;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            mul_a    = MUL_A_W'(diff_ff);
            mul_b    = (m1_ff == MODE_EASE) ? prod_hi : frac_ff;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            vol_in   = rising_ff ? (l1_ff + delta) : (l1_ff - delta);
            src_in   = SRC_SEGMENT;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_volume_in = rsp_volume_ff;
      rsp_source_in = rsp_source_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_volume_in = vol_ff;
         rsp_source_in = src_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_volume_ff);
   assign rsp_tuser  = rsp_source_ff;

   // ---------------- register port ----------------
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      empty_volume_in   = empty_volume_ff;
      keyframe_count_in = keyframe_count_ff;
      if (csr_write) begin
         unique case (csr_paddr[CSR_IDX_BIT])
            CSR_IDX_EMPTY_VOLUME:   empty_volume_in   = csr_pwdata[LEVEL_WIDTH-1:0];
            CSR_IDX_KEYFRAME_COUNT: keyframe_count_in = csr_pwdata[COUNT_W-1:0];
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[CSR_IDX_BIT] == CSR_IDX_KEYFRAME_COUNT)
                       ? CSR_DATA_W'(keyframe_count_ff)
                       : CSR_DATA_W'(empty_volume_ff);

   // ---------------- flops ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         empty_volume_ff   <= LEVEL_WIDTH'(EMPTY_VOLUME_RESET);
         keyframe_count_ff <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         empty_volume_ff   <= empty_volume_in;
         keyframe_count_ff <= keyframe_count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      addr_ff       <= rd_addr;
      level0_ff     <= level0_in;
      t1_ff         <= t1_in;
      l1_ff         <= l1_in;
      m1_ff         <= m1_in;
      rising_ff     <= rising_in;
      diff_ff       <= diff_in;
      frac_ff       <= frac_in;
      vol_ff        <= vol_in;
      src_ff        <= src_in;
      rsp_volume_ff <= rsp_volume_in;
      rsp_source_ff <= rsp_source_in;
   end

endmodule

`default_nettype wire

FILE: sv/kve_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kve_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/kve_frac_div.sv
// Bit-serial Q0.16 fraction unit: quotient = floor(num * 2^16 / den), num < den.
// One quotient bit per cycle. Depends on kve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kve_frac_div #(
   parameter int WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [WIDTH-1:0]           num,
   input  wire logic [WIDTH-1:0]           den,
   output logic                            done,
   output logic      [kve_pkg::FRAC_W-1:0] quotient
);

   import kve_pkg::*;

   localparam int STEP_W = $clog2(FRAC_W);

   logic [WIDTH-1:0]  rem_ff, rem_in;
   logic [WIDTH-1:0]  den_ff, den_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WIDTH+1:0]  trial;
   logic              last_step;

   // 2r - den; remainder stays below den so 2r never overflows WIDTH+1 bits
   assign trial     = {1'b0, rem_ff, 1'b0} - {2'b00, den_ff};
   assign last_step = (step_ff == STEP_W'(FRAC_W - 1));

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WIDTH+1]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], 1'b0};
            quo_in = {quo_ff[FRAC_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: sv/kve_mul.sv
// Shared unsigned multiplier with a registered product.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module kve_mul #(
   parameter int A_WIDTH = 18,
   parameter int B_WIDTH = 16
) (
   input  wire logic                       clock,
   input  wire logic [A_WIDTH-1:0]         a,
   input  wire logic [B_WIDTH-1:0]         b,
   output logic      [A_WIDTH+B_WIDTH-1:0] product
);

   logic [A_WIDTH+B_WIDTH-1:0] product_ff, product_in;

   assign product_in = (A_WIDTH + B_WIDTH)'(a) * (A_WIDTH + B_WIDTH)'(b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for keyframe_volume_envelope: keyframe writes and envelope
// queries on the request stream, register writes on the APB port.
// Depends on kve_pkg and the keyframe_volume_envelope RTL.
`timescale 1ns / 1ps

typedef struct packed {
   logic [15:0] volume;
   logic [1:0]  source;
} envelope_result_type;

// Mirror of the keyframe table and registers plus the queue of volumes owed.
class envelope_checker_type;
   logic [31:0] key_time  [64];
   logic [15:0] key_level [64];
   logic [1:0]  key_mode  [64];
   logic [15:0] empty_volume;
   logic [6:0]  keyframe_count;
   envelope_result_type owed_volumes[$];
   int mismatches;

   function new();
      foreach (key_time[i]) begin
         key_time[i]  = '0;
         key_level[i] = '0;
         key_mode[i]  = '0;
      end
      empty_volume   = 16'(kve_pkg::EMPTY_VOLUME_RESET);
      keyframe_count = '0;
      mismatches     = 0;
   endfunction

   function void set_register(logic idx, logic [31:0] value);
      if (idx == kve_pkg::CSR_IDX_EMPTY_VOLUME) begin
         empty_volume = value[15:0];
      end else begin
         keyframe_count = value[6:0];
      end
   endfunction

   // volume at query time q against the current table
   function envelope_result_type envelope_at(logic [31:0] q);
      int n, lo, hi, mid;
      bit [63:0] num, den, f, sq, a, b;
      envelope_result_type r;
      n = (keyframe_count > 64) ? 64 : int'(keyframe_count);
      if (n == 0) begin
         r.volume = empty_volume;
         r.source = kve_pkg::SRC_DEFAULT;
      end else if (q <= key_time[0]) begin
         r.volume = key_level[0];
         r.source = kve_pkg::SRC_FIRST;
      end else if (q >= key_time[n-1]) begin
         r.volume = key_level[n-1];
         r.source = kve_pkg::SRC_LAST;
      end else begin
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (q < key_time[mid]) hi = mid;
            else lo = mid + 1;
         end
         r.source = kve_pkg::SRC_SEGMENT;
         if (lo == 0 || lo >= n) begin
            r.volume = key_level[0];
            r.source = kve_pkg::SRC_FIRST;
         end else if (key_time[lo] <= key_time[lo-1] || q < key_time[lo-1] ||
                      q >= key_time[lo] || key_mode[lo-1] == kve_pkg::MODE_HOLD) begin
            r.volume = key_level[lo-1];
         end else begin
            num = 64'(q) - 64'(key_time[lo-1]);
            den = 64'(key_time[lo]) - 64'(key_time[lo-1]);
            f = (num << 16) / den;
            if (key_mode[lo-1] == kve_pkg::MODE_EASE) begin
               sq = (f * f) >> 16;
               f = (sq * (64'(kve_pkg::EASE_THREE) - 2 * f)) >> 16;
            end
            a = 64'(key_level[lo-1]);
            b = 64'(key_level[lo]);
            if (b >= a) r.volume = 16'(a + (((b - a) * f) >> 16));
            else r.volume = 16'(a - (((a - b) * f) >> 16));
         end
      end
      return r;
   endfunction

   function void accept_request(logic cmd, logic [31:0] tick, logic [5:0] slot,
                                logic [15:0] level, logic [1:0] mode);
      if (cmd == kve_pkg::CMD_WRITE) begin
         key_time[slot]  = tick;
         key_level[slot] = level;
         key_mode[slot]  = mode;
      end else begin
         owed_volumes.push_back(envelope_at(tick));
      end
   endfunction

   function void compare_volume(logic [15:0] volume, logic [1:0] source);
      envelope_result_type e;
      if (owed_volumes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: volume %h source %0d", volume, source);
         return;
      end
      e = owed_volumes.pop_front();
      if (e.volume !== volume || e.source !== source) begin
         mismatches++;
         if (mismatches <= 10)
            $display("volume mismatch: expected %h/%0d, got %h/%0d",
                     e.volume, e.source, volume, source);
      end
   endfunction

   function int outstanding();
      return owed_volumes.size();
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE       = 64;    // longer than the worst evaluate takes
   localparam int ITEM_TARGET  = 800;

   // linear codes; hold and ease come from the package
   localparam logic [1:0] MODE_LINEAR     = 2'd0;
   localparam logic [1:0] MODE_LINEAR_ALT = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: tick_time[31:0], slot[37:32], level[53:38], mode[55:54]
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;   // cmd

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // volume
   logic [1:0]  rsp_tuser;          // source

   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   envelope_checker_type board;
   bit  calm = 1'b0;    // phase with no idling on either side
   int  items_sent = 0;
   int  rsp_stall = 0;
   int  cycles = 0;

   always #6 clock = ~clock;

   keyframe_volume_envelope dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: check on handshake, then draw a stall for the next result
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.compare_volume(rsp_tdata, rsp_tuser);
            rsp_stall = calm ? 0 : $urandom_range(0, 13);
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // one request; returns at the edge where it was taken
   task automatic send_request(input logic cmd, input logic [31:0] tick,
                               input logic [5:0] slot, input logic [15:0] level,
                               input logic [1:0] mode);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {mode, level, slot, tick};
      do @(posedge clock); while (!req_tready);
      board.accept_request(cmd, tick, slot, level, mode);
      items_sent++;
   endtask

   // evaluate; unused fields carry junk
   task automatic query_envelope(input logic [31:0] tick);
      send_request(kve_pkg::CMD_EVAL, tick, 6'($urandom), 16'($urandom), 2'($urandom));
   endtask

   // hold off until every owed volume is back, then let a trailing write retire
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write: setup cycle, access until pready, then back to idle
   task automatic write_register(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(idx) << kve_pkg::CSR_IDX_BIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic run_directed();
      // empty table at reset default, then the default extremes
      query_envelope(32'h0000_0000);
      query_envelope(32'hFFFF_FFFF);
      wait_drained();
      write_register(kve_pkg::CSR_IDX_EMPTY_VOLUME, 32'h0000_FFFF);
      query_envelope(32'h1234_5678);
      wait_drained();
      write_register(kve_pkg::CSR_IDX_EMPTY_VOLUME, 32'h0000_0000);
      query_envelope(32'h8765_4321);
      // five keys: linear up, ease down, hold, equal times, full-range last
      send_request(kve_pkg::CMD_WRITE, 32'h0000_0010, 6'd0, 16'h0000, MODE_LINEAR);
      send_request(kve_pkg::CMD_WRITE, 32'h0000_1000, 6'd1, 16'hFFFF, kve_pkg::MODE_EASE);
      send_request(kve_pkg::CMD_WRITE, 32'h0000_2000, 6'd2, 16'h0000, kve_pkg::MODE_HOLD);
      send_request(kve_pkg::CMD_WRITE, 32'h0000_2000, 6'd3, 16'h1234, MODE_LINEAR_ALT);
      send_request(kve_pkg::CMD_WRITE, 32'hFFFF_FFFF, 6'd63, 16'h8000, MODE_LINEAR);
      send_request(kve_pkg::CMD_WRITE, 32'hFFFF_FFFF, 6'd4, 16'h8000, MODE_LINEAR);
      wait_drained();
      write_register(kve_pkg::CSR_IDX_KEYFRAME_COUNT, 32'd5);
      query_envelope(32'h0000_0000);    // before first key
      query_envelope(32'h0000_0010);    // on first key
      query_envelope(32'h0000_0011);    // tiny fraction
      query_envelope(32'h0000_0808);    // linear rise
      query_envelope(32'h0000_1800);    // ease fall
      query_envelope(32'h0000_1FFF);    // end of the ease fall
      query_envelope(32'h0000_2000);    // on the equal pair
      query_envelope(32'h8000_0000);    // long last segment
      query_envelope(32'hFFFF_FFFF);    // on last key
      // break ordering: entry one now earlier than entry zero
      send_request(kve_pkg::CMD_WRITE, 32'h0000_0005, 6'd1, 16'hFFFF, kve_pkg::MODE_EASE);
      query_envelope(32'h0000_0800);
   endtask

   task automatic run_random_phase(input int forced_count);
      int count_value, keys, evals, pick, sel, j;
      bit shuffled;
      bit [63:0] stamp, step_max;
      logic [31:0] times [64];
      logic [31:0] span_lo, span_hi, q, dv;
      logic [5:0] slot;

      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (forced_count >= 0) count_value = forced_count;
      else if (pick == 0) count_value = 0;
      else if (pick == 1) count_value = $urandom_range(65, 127);   // saturates
      else if (pick == 2) count_value = $urandom_range(17, 64);
      else count_value = $urandom_range(1, 16);
      if (count_value == 0) keys = $urandom_range(0, 8);
      else keys = (count_value > 64) ? 64 : count_value;
      shuffled = ($urandom_range(0, 7) == 0);

      pick = $urandom_range(0, 3);
      dv = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF : 32'($urandom_range(0, 16'hFFFF));

      // registers only while idle
      wait_drained();
      write_register(kve_pkg::CSR_IDX_EMPTY_VOLUME, dv);
      write_register(kve_pkg::CSR_IDX_KEYFRAME_COUNT, 32'(count_value));

      // mostly sorted times from a random base; step size picks the scale
      step_max = 64'd1 << $urandom_range(0, 26);
      stamp = 64'($urandom);
      for (int i = 0; i < keys; i++) begin
         if (shuffled) begin
            times[i] = $urandom;
         end else begin
            times[i] = (stamp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stamp[31:0];
            if ($urandom_range(0, 9) != 0)
               stamp += 64'($urandom_range(0, 32'(step_max)));
         end
         send_request(kve_pkg::CMD_WRITE, times[i], 6'(i), 16'($urandom), 2'($urandom));
      end

      span_lo = (keys > 0) ? times[0] : 32'h0;
      span_hi = (keys > 0) ? times[keys-1] : 32'hFFFF_FFFF;
      evals = $urandom_range(8, 40);
      for (int k = 0; k < evals; k++) begin
         sel = $urandom_range(0, 15);
         if (sel == 0) begin
            // rewrite a key: same time inside the table keeps it ordered
            slot = 6'($urandom);
            q = (slot < keys) ? times[slot] : $urandom;
            send_request(kve_pkg::CMD_WRITE, q, slot, 16'($urandom), 2'($urandom));
         end else begin
            j = (keys > 0) ? $urandom_range(0, keys - 1) : 0;
            if (sel <= 3 && keys > 0) q = times[j];
            else if (sel == 4 && keys > 0) q = ($urandom_range(0, 1) != 0) ? times[j] + 1
                                                                          : times[j] - 1;
            else if (sel <= 12) q = $urandom_range(span_lo, span_hi);
            else q = $urandom;
            query_envelope(q);
         end
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      // full table, then an oversized count over the same depth
      run_random_phase(64);
      run_random_phase(127);
      while (items_sent < ITEM_TARGET) run_random_phase(-1);

      calm = 1'b0;
      wait_drained();
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/kve_pkg.sv
sv/kve_ram.sv
sv/kve_frac_div.sv
sv/kve_mul.sv
sv/keyframe_volume_envelope.sv
tb/tb_top.sv
